// ===== rtl/i8mmchk_pkg.sv =====
// shared types and constants for the int8 matrix multiply checker
// no dependencies; used by int8_matrix_multiply_check
`default_nettype none

package i8mmchk_pkg;

   // default store dimensions
   localparam int MAX_ROWS_DEF  = 16;
   localparam int MAX_DEPTH_DEF = 64;
   localparam int MAX_COLS_DEF  = 64;

   // register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] REG_DIM_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIM_DEPTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DIM_COLS  = 2'd2;

   localparam logic [4:0] DIM_ROWS_RST  = 5'd16;
   localparam logic [6:0] DIM_DEPTH_RST = 7'd64;
   localparam logic [6:0] DIM_COLS_RST  = 7'd64;

   // error counter
   localparam int ERR_W = 11;
   localparam logic [ERR_W-1:0] ERR_LIMIT = 11'd1024;

   typedef enum logic [1:0] {
      CMD_LOAD_ACT = 2'd0,
      CMD_LOAD_WGT = 2'd1,
      CMD_COMPUTE  = 2'd2,
      CMD_CLEAR    = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [5:0]         row_index;
      logic [5:0]         col_index;
      logic signed [7:0]  elem_value;
      logic signed [15:0] golden_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] dot_result;
      logic               mismatch;
      logic [ERR_W-1:0]   error_total;
      logic               all_match;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/int8_matrix_multiply_check.sv =====
// int8 matrix multiply checker: activation and weight stores, one-port mac loop,
// golden compare and saturating mismatch counter; depends on i8mmchk_pkg
`default_nettype none

// Load and clear requests complete on acceptance. A compute request reads
// depth elements from each store, where depth is the configured reduction length:
// each store has a single synchronous read port, so one activation and one weight
// are read per cycle, followed by a multiply stage, an accumulate stage and a
// compare stage. The block works on one compute request at a time and holds
// req_stall high until its response is registered; loads and clears are still
// taken while a response waits on rsp_stall. A compute outside the configured
// rows or columns answers with a zero result. Store contents are undefined
// until loaded.
module int8_matrix_multiply_check #(
   parameter int MAX_ROWS  = i8mmchk_pkg::MAX_ROWS_DEF,
   parameter int MAX_DEPTH = i8mmchk_pkg::MAX_DEPTH_DEF,
   parameter int MAX_COLS  = i8mmchk_pkg::MAX_COLS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire i8mmchk_pkg::req_type             req_data,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output i8mmchk_pkg::rsp_type                  rsp_data,

   input  wire logic                             csr_we,
   input  wire logic [i8mmchk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [i8mmchk_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int ACT_DEPTH = MAX_ROWS * MAX_DEPTH;
   localparam int WGT_DEPTH = MAX_DEPTH * MAX_COLS;
   localparam int AAW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
   localparam int WAW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
   localparam int DCW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int ERR_W = i8mmchk_pkg::ERR_W;

   localparam logic [10:0] ROWS_LIM  = 11'(MAX_ROWS);
   localparam logic [10:0] DEPTH_LIM = 11'(MAX_DEPTH);
   localparam logic [10:0] COLS_LIM  = 11'(MAX_COLS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FIN
   } state_type;

   function automatic logic [10:0] clamp_dim(input logic [6:0] v, input logic [10:0] lim);
      logic [10:0] w;
      w = {4'b0, v};
      if (w == 11'd0) begin
         return 11'd1;
      end
      if (w > lim) begin
         return lim;
      end
      return w;
   endfunction

   // configuration
   logic [4:0] dim_rows_ff;
   logic [6:0] dim_depth_ff;
   logic [6:0] dim_cols_ff;

   // control
   state_type        state_ff;
   logic             skip_ff;
   logic [DCW-1:0]   d_ff;
   logic             rd_vld_ff;
   logic             rd_last_ff;
   logic             prod_vld_ff;
   logic             prod_last_ff;
   logic [ERR_W-1:0] err_cnt_ff;
   logic             rsp_valid_ff;

   // datapath
   logic [AAW-1:0]     act_addr_ff;
   logic [WAW-1:0]     wgt_addr_ff;
   logic signed [7:0]  act_q_ff;
   logic signed [7:0]  wgt_q_ff;
   logic signed [15:0] prod_ff;
   logic [15:0]        acc_ff;
   logic [15:0]        golden_ff;
   i8mmchk_pkg::rsp_type rsp_data_ff;

   logic [7:0] act_mem [ACT_DEPTH];
   logic [7:0] wgt_mem [WGT_DEPTH];

   logic [10:0]        rows_eff;
   logic [10:0]        depth_eff;
   logic [10:0]        cols_eff;
   logic [DCW-1:0]     d_last;
   logic               req_fire;
   logic               act_we;
   logic               wgt_we;
   logic [AAW-1:0]     act_waddr;
   logic [WAW-1:0]     wgt_waddr;
   logic               in_range;
   logic               issue;
   logic               fin_fire;
   logic               miss_in;
   logic [ERR_W-1:0]   err_cnt_in;
   logic signed [15:0] prod_in;

   assign rows_eff  = clamp_dim({2'b0, dim_rows_ff}, ROWS_LIM);
   assign depth_eff = clamp_dim(dim_depth_ff, DEPTH_LIM);
   assign cols_eff  = clamp_dim(dim_cols_ff, COLS_LIM);
   assign d_last    = DCW'(depth_eff - 11'd1);

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;

   assign act_we = req_fire && (req_data.cmd == i8mmchk_pkg::CMD_LOAD_ACT)
                   && (32'(req_data.row_index) < 32'(MAX_ROWS))
                   && (32'(req_data.col_index) < 32'(MAX_DEPTH));
   assign wgt_we = req_fire && (req_data.cmd == i8mmchk_pkg::CMD_LOAD_WGT)
                   && (32'(req_data.row_index) < 32'(MAX_DEPTH))
                   && (32'(req_data.col_index) < 32'(MAX_COLS));
   assign act_waddr = AAW'(32'(req_data.row_index) * 32'(MAX_DEPTH)
                           + 32'(req_data.col_index));
   assign wgt_waddr = WAW'(32'(req_data.row_index) * 32'(MAX_COLS)
                           + 32'(req_data.col_index));

   assign in_range = ({5'b0, req_data.row_index} < rows_eff)
                     && ({5'b0, req_data.col_index} < cols_eff);

   assign issue    = (state_ff == ST_RUN);
   assign fin_fire = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign miss_in  = !skip_ff && (acc_ff != golden_ff);
   assign err_cnt_in = (miss_in && (err_cnt_ff != i8mmchk_pkg::ERR_LIMIT))
                       ? err_cnt_ff + 11'd1 : err_cnt_ff;
   assign prod_in  = 16'(act_q_ff) * 16'(wgt_q_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_rows_ff  <= i8mmchk_pkg::DIM_ROWS_RST;
         dim_depth_ff <= i8mmchk_pkg::DIM_DEPTH_RST;
         dim_cols_ff  <= i8mmchk_pkg::DIM_COLS_RST;
      end else if (csr_we) begin
         case (csr_index)
            i8mmchk_pkg::REG_DIM_ROWS:  dim_rows_ff  <= csr_wdata[4:0];
            i8mmchk_pkg::REG_DIM_DEPTH: dim_depth_ff <= csr_wdata[6:0];
            i8mmchk_pkg::REG_DIM_COLS:  dim_cols_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // stores
   always_ff @(posedge clock) begin
      if (act_we) begin
         act_mem[act_waddr] <= req_data.elem_value;
      end
      act_q_ff <= act_mem[act_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (wgt_we) begin
         wgt_mem[wgt_waddr] <= req_data.elem_value;
      end
      wgt_q_ff <= wgt_mem[wgt_addr_ff];
   end

   // control and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         skip_ff      <= 1'b0;
         d_ff         <= '0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         prod_vld_ff  <= 1'b0;
         prod_last_ff <= 1'b0;
         err_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= issue;
         rd_last_ff   <= issue && (d_ff == d_last);
         prod_vld_ff  <= rd_vld_ff;
         prod_last_ff <= rd_last_ff;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (req_data.cmd)
                     i8mmchk_pkg::CMD_COMPUTE: begin
                        d_ff     <= '0;
                        skip_ff  <= !in_range;
                        state_ff <= in_range ? ST_RUN : ST_FIN;
                     end
                     i8mmchk_pkg::CMD_CLEAR: begin
                        err_cnt_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_RUN: begin
               d_ff <= d_ff + DCW'(1);
               if (d_ff == d_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (prod_vld_ff && prod_last_ff) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (fin_fire) begin
                  err_cnt_ff   <= err_cnt_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire && (req_data.cmd == i8mmchk_pkg::CMD_COMPUTE)) begin
         act_addr_ff <= AAW'(32'(req_data.row_index) * 32'(MAX_DEPTH));
         wgt_addr_ff <= WAW'(req_data.col_index);
         golden_ff   <= req_data.golden_value;
         acc_ff      <= '0;
      end else begin
         if (issue) begin
            act_addr_ff <= act_addr_ff + AAW'(1);
            wgt_addr_ff <= wgt_addr_ff + WAW'(MAX_COLS);
         end
         if (prod_vld_ff) begin
            acc_ff <= acc_ff + prod_ff;
         end
      end
      prod_ff <= prod_in;
      if (fin_fire) begin
         rsp_data_ff.dot_result  <= skip_ff ? 16'sd0 : acc_ff;
         rsp_data_ff.mismatch    <= miss_in;
         rsp_data_ff.error_total <= err_cnt_in;
         rsp_data_ff.all_match   <= (err_cnt_in == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (state_ff == ST_IDLE))
      else $error("request accepted while busy");

   a_err_limit: assert property (@(posedge clock) disable iff (reset)
      err_cnt_ff <= i8mmchk_pkg::ERR_LIMIT)
      else $error("error counter beyond limit");

   a_err_step: assert property (@(posedge clock) disable iff (reset)
      (fin_fire && miss_in && (err_cnt_ff != i8mmchk_pkg::ERR_LIMIT))
      |=> (err_cnt_ff == ($past(err_cnt_ff) + 11'd1)))
      else $error("mismatch not counted");

   a_all_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.all_match == (rsp_data_ff.error_total == '0)))
      else $error("all_match disagrees with error total");

   a_pipe_busy: assert property (@(posedge clock) disable iff (reset)
      (rd_vld_ff || prod_vld_ff) |-> ((state_ff == ST_RUN) || (state_ff == ST_DRAIN)))
      else $error("read pipeline active outside compute");

endmodule

`default_nettype wire

// ===== sim/i8mmchk_score_pkg.sv =====
// scoreboard for the int8 matrix multiply checker: predicts the stores, the
// dimension registers and the mismatch counter, and checks each response in order
// depends on i8mmchk_pkg
package i8mmchk_score_pkg;
   import i8mmchk_pkg::*;

   class matmul_scoreboard;
      logic signed [7:0] act_mem [MAX_ROWS_DEF][MAX_DEPTH_DEF];
      logic signed [7:0] wgt_mem [MAX_DEPTH_DEF][MAX_COLS_DEF];
      bit                act_loaded [MAX_ROWS_DEF][MAX_DEPTH_DEF];
      bit                wgt_loaded [MAX_DEPTH_DEF][MAX_COLS_DEF];
      logic [4:0]        rows_reg;
      logic [6:0]        depth_reg;
      logic [6:0]        cols_reg;
      logic [ERR_W-1:0]  err_count;
      rsp_type           expected_results [$];
      int                fail_count;

      function new();
         rows_reg   = DIM_ROWS_RST;
         depth_reg  = DIM_DEPTH_RST;
         cols_reg   = DIM_COLS_RST;
         err_count  = '0;
         fail_count = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_DIM_ROWS: rows_reg = value[4:0];
            REG_DIM_DEPTH: depth_reg = value;
            REG_DIM_COLS: cols_reg = value;
            default: ;
         endcase
      endfunction

      function int clamp_dim(int v, int limit);
         if (v == 0) return 1;
         if (v > limit) return limit;
         return v;
      endfunction

      function int eff_rows();
         return clamp_dim(rows_reg, MAX_ROWS_DEF);
      endfunction

      function int eff_depth();
         return clamp_dim(depth_reg, MAX_DEPTH_DEF);
      endfunction

      function int eff_cols();
         return clamp_dim(cols_reg, MAX_COLS_DEF);
      endfunction

      // signed sum over the configured depth, low 16 bits kept
      function logic signed [15:0] dot_at(int r, int c);
         int acc;
         acc = 0;
         for (int d = 0; d < eff_depth(); d++) begin
            acc += int'(act_mem[r][d]) * int'(wgt_mem[d][c]);
         end
         return acc[15:0];
      endfunction

      function void note_request(req_type q);
         rsp_type           want;
         logic signed [15:0] dot;
         int                r;
         int                c;
         r = q.row_index;
         c = q.col_index;
         case (q.cmd)
            CMD_LOAD_ACT: begin
               if (r < MAX_ROWS_DEF && c < MAX_DEPTH_DEF) begin
                  act_mem[r][c]    = q.elem_value;
                  act_loaded[r][c] = 1'b1;
               end
            end
            CMD_LOAD_WGT: begin
               if (r < MAX_DEPTH_DEF && c < MAX_COLS_DEF) begin
                  wgt_mem[r][c]    = q.elem_value;
                  wgt_loaded[r][c] = 1'b1;
               end
            end
            CMD_CLEAR: begin
               err_count = '0;
            end
            CMD_COMPUTE: begin
               want = '0;
               if (r < eff_rows() && c < eff_cols()) begin
                  dot = dot_at(r, c);
                  want.dot_result = dot;
                  want.mismatch = (dot != q.golden_value);
                  if (want.mismatch && err_count < ERR_LIMIT) err_count++;
               end
               want.error_total = err_count;
               want.all_match = (err_count == '0);
               expected_results.push_back(want);
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string msg);
         fail_count++;
         if (fail_count <= 100) $display("error: %s", msg);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("response with no request outstanding: %h", got));
            return;
         end
         want = expected_results.pop_front();
         if (got.dot_result !== want.dot_result)
            report_mismatch($sformatf("dot_result %0d, want %0d", got.dot_result,
                                      want.dot_result));
         if (got.mismatch !== want.mismatch)
            report_mismatch($sformatf("mismatch %b, want %b", got.mismatch, want.mismatch));
         if (got.error_total !== want.error_total)
            report_mismatch($sformatf("error_total %0d, want %0d", got.error_total,
                                      want.error_total));
         if (got.all_match !== want.all_match)
            report_mismatch($sformatf("all_match %b, want %b", got.all_match, want.all_match));
      endtask

      function int pending();
         return expected_results.size();
      endfunction

      task flush_check();
         if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_results.size()));
      endtask
   endclass

endpackage

// ===== sim/tb.sv =====
// testbench for int8_matrix_multiply_check: directed loads and computes, then
// random phases over several dimension settings with random stalls on both sides
// depends on i8mmchk_pkg, i8mmchk_score_pkg and the rtl
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i8mmchk_pkg::*;
   import i8mmchk_score_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam int IDLE_PCT    = 28;
   localparam int LOAD_SETTLE = 4;
   localparam int DRAIN_LIMIT = 20000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bit                    steady = 1'b0;
   int                    holdoff_request = 0;
   bit                    holdoff_taken = 1'b0;
   int                    holdoff_left = 0;
   int                    requests_sent = 0;
   matmul_scoreboard      sb = new();

   always #1 clock = ~clock;

   int8_matrix_multiply_check i_dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .csr_we,
      .csr_index,
      .csr_wdata
   );

   // response side: check, then choose the next stall
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall == 1'b0) sb.check_result(rsp_data);
      if (holdoff_request > 0 && !holdoff_taken) begin
         holdoff_left = holdoff_request;
         holdoff_taken = 1'b1;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   function automatic req_type make_req(cmd_type cmd, int r, int c, int elem, int golden);
      req_type q;
      q.cmd          = cmd;
      q.row_index    = r[5:0];
      q.col_index    = c[5:0];
      q.elem_value   = elem[7:0];
      q.golden_value = golden[15:0];
      return q;
   endfunction

   function automatic int pick_elem();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return -128;
      if (p == 1) return 127;
      return $urandom_range(0, 255);
   endfunction

   function automatic int pick_golden();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return -32768;
      if (p == 1) return 32767;
      return $urandom_range(0, 65535);
   endfunction

   task automatic send(req_type q);
      req_data  <= q;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_request(q);
      requests_sent++;
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic load(cmd_type cmd, int r, int c, int elem);
      send(make_req(cmd, r, c, elem, $urandom_range(0, 65535)));
   endtask

   // fills any element the position needs that was never loaded
   task automatic compute_at(int r, int c, int match_pct);
      int golden;
      if (r < sb.eff_rows() && c < sb.eff_cols()) begin
         for (int d = 0; d < sb.eff_depth(); d++) begin
            if (!sb.act_loaded[r][d]) load(CMD_LOAD_ACT, r, d, pick_elem());
            if (!sb.wgt_loaded[d][c]) load(CMD_LOAD_WGT, d, c, pick_elem());
         end
      end
      golden = pick_golden();
      if (r < sb.eff_rows() && c < sb.eff_cols() && $urandom_range(0, 99) < match_pct)
         golden = sb.dot_at(r, c);
      send(make_req(CMD_COMPUTE, r, c, pick_elem(), golden));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (LOAD_SETTLE) @(posedge clock);
   endtask

   task automatic write_dims(int r, int d, int c);
      int spare;
      spare = $urandom_range(0, 127);
      csr_we    <= 1'b1;
      csr_index <= REG_DIM_ROWS;
      csr_wdata <= r[6:0];
      @(posedge clock);
      sb.set_register(REG_DIM_ROWS, r[6:0]);
      csr_index <= REG_DIM_DEPTH;
      csr_wdata <= d[6:0];
      @(posedge clock);
      sb.set_register(REG_DIM_DEPTH, d[6:0]);
      csr_index <= REG_DIM_COLS;
      csr_wdata <= c[6:0];
      @(posedge clock);
      sb.set_register(REG_DIM_COLS, c[6:0]);
      csr_index <= REG_SPARE;
      csr_wdata <= spare[6:0];
      @(posedge clock);
      sb.set_register(REG_SPARE, spare[6:0]);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(int r, int d, int c, int n, int compute_pct, int in_range_pct,
                            int match_pct, bit with_clear);
      int start;
      int p;
      drain();
      write_dims(r, d, c);
      start = requests_sent;
      while (requests_sent - start < n) begin
         if ($urandom_range(0, 99) < compute_pct) begin
            if ($urandom_range(0, 99) < in_range_pct)
               compute_at($urandom_range(0, sb.eff_rows() - 1),
                          $urandom_range(0, sb.eff_cols() - 1), match_pct);
            else
               compute_at($urandom_range(0, 63), $urandom_range(0, 63), match_pct);
         end else begin
            p = $urandom_range(0, 99);
            if (p < 40)
               load(CMD_LOAD_ACT, $urandom_range(0, MAX_ROWS_DEF - 1), $urandom_range(0, 63),
                    pick_elem());
            else if (p < 80 || (p < 90 && !with_clear))
               load(CMD_LOAD_WGT, $urandom_range(0, 63), $urandom_range(0, 63), pick_elem());
            else if (p < 90)
               send(make_req(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                             pick_elem(), pick_golden()));
            else
               load(CMD_LOAD_ACT, $urandom_range(MAX_ROWS_DEF, 63), $urandom_range(0, 63),
                    pick_elem());
         end
      end
   endtask

   initial begin
      int wait_cycles;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, truncation, out of range, clear
      write_dims(16, 2, 64);
      load(CMD_LOAD_ACT, 0, 0, -128);
      load(CMD_LOAD_ACT, 0, 1, -128);
      load(CMD_LOAD_WGT, 0, 0, -128);
      load(CMD_LOAD_WGT, 1, 0, -128);
      send(make_req(CMD_COMPUTE, 0, 0, 0, -32768));
      load(CMD_LOAD_ACT, 15, 0, 127);
      load(CMD_LOAD_ACT, 15, 1, 127);
      load(CMD_LOAD_WGT, 0, 63, 127);
      load(CMD_LOAD_WGT, 1, 63, 127);
      send(make_req(CMD_COMPUTE, 15, 63, 127, 32767));
      send(make_req(CMD_COMPUTE, 0, 63, -1, 0));
      send(make_req(CMD_COMPUTE, 16, 0, 0, 5));
      send(make_req(CMD_COMPUTE, 63, 63, -1, -1));
      load(CMD_LOAD_ACT, 16, 5, 1);
      load(CMD_LOAD_ACT, 63, 63, -1);
      send(make_req(CMD_CLEAR, 63, 63, -1, -1));
      send(make_req(CMD_COMPUTE, 15, 0, 0, -32512));
      load(CMD_LOAD_WGT, 63, 62, -1);
      load(CMD_LOAD_ACT, 0, 63, 127);
      send(make_req(CMD_COMPUTE, 15, 0, 0, 32767));

      // response side held off while computes keep coming
      drain();
      write_dims(4, 8, 4);
      holdoff_request = 300;
      compute_at(0, 0, 50);
      compute_at(1, 1, 50);
      compute_at(3, 3, 50);
      compute_at(2, 0, 50);

      run_phase(4, 8, 4, 150, 45, 80, 50, 1'b1);
      run_phase(16, 64, 64, 300, 40, 80, 40, 1'b1);
      run_phase(0, 0, 0, 100, 45, 80, 40, 1'b1);
      run_phase(31, 127, 127, 150, 40, 80, 40, 1'b1);
      // counter runs into saturation, no idling on either side
      steady = 1'b1;
      run_phase(1, 1, 1, 1100, 100, 100, 0, 1'b0);
      steady = 1'b0;
      run_phase(7, 33, 9, 150, 45, 80, 40, 1'b1);
      repeat (2) begin
         run_phase($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16), 120,
                   45, 80, 40, 1'b1);
      end

      req_valid <= 1'b0;
      wait_cycles = 0;
      while (sb.pending() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (80) @(posedge clock);
      sb.flush_check();
      if (sb.fail_count == 0) begin
         $display("int8_matrix_multiply_check regression: pass");
      end else begin
         $display("int8_matrix_multiply_check regression: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("int8_matrix_multiply_check regression: fail");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/i8mmchk_pkg.sv
rtl/int8_matrix_multiply_check.sv
sim/i8mmchk_score_pkg.sv
sim/tb.sv
